// File: src/dcpt_pkg.sv
// Shared widths, reset values and register indexes of the drift-compensated period timer.
package dcpt_pkg;

  localparam int TS_W    = 48;
  localparam int CFG_W   = 24;
  localparam int DRIFT_W = 32;
  localparam int TOTAL_W = 56;
  localparam int CNT_W   = 6;

  typedef logic [TS_W-1:0]    ts_t;
  typedef logic [CFG_W-1:0]   cfg_t;
  typedef logic [TOTAL_W-1:0] total_t;

  localparam cfg_t PERIOD_RESET = 24'd10000;
  localparam cfg_t LIMIT_RESET  = 24'd10000;
  localparam cfg_t CFG_MAX      = 24'hFF_FFFF;

  // Register indexes on the configuration port
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  // Last dividend bit index of the serial divider
  localparam logic [CNT_W-1:0] DIV_LAST = 6'd55;

endpackage

// File: src/drift_compensated_period_timer.sv
// Drift-compensated period timer: drift, running mean and corrected wait per firing.
//
// Usage: each input item on timestamp_us (in_valid / in_stall) is the absolute
// microsecond time of one firing. For every item one result is produced on
// drift_us, wait_us and last_firing (out_valid / out_stall): the drift of this
// firing against the previous one, the corrected wait before the next firing
// and a flag on the firing that reaches task_limit.
// The configuration port (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
// period_us (index 0) and task_limit (index 1); it is always ready.
// The first firing after reset passes the elapsed, drift and final steps to
// the result register; every later firing also passes the accumulate and load
// steps and the bit-serial restoring divider, which forms the mean drift one
// quotient bit per cycle over the 56-bit drift sum. One item is worked on at a
// time, so no new item is taken until the last is done; in_stall is high while an item is in work.
// A finished result waits in the output register while out_stall is high, and
// the next item is accepted and worked on meanwhile; it is held at its last
// step until the output register is free.
// Reset (rst, synchronous) restores period_us and task_limit to 10000 and
// clears the previous time, the firing count, the drift sum and out_valid.
module drift_compensated_period_timer
  import dcpt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [TS_W-1:0]           timestamp_us,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DRIFT_W-1:0] drift_us,
  output logic [CFG_W-1:0]          wait_us,
  output logic                      last_firing
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ELAP  = 3'd1;
  localparam logic [2:0] S_DRIFT = 3'd2;
  localparam logic [2:0] S_ACCUM = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]         state;
  cfg_t               period;
  cfg_t               limit;
  ts_t                prev;
  cfg_t               count;
  total_t             total;

  ts_t                ts;
  logic [TS_W:0]      elapsed;
  logic [DRIFT_W-1:0] drift;
  logic               first;
  logic               last;
  logic               neg;
  cfg_t               divisor;
  total_t             dvd;
  cfg_t               rem;
  logic [CNT_W-1:0]   bit_cnt;

  logic               in_acc;
  logic               out_free;
  logic [TS_W+1:0]    drift_full;
  logic [DRIFT_W-1:0] drift_next;
  logic [TOTAL_W:0]   sum_full;
  total_t             total_next;
  logic [CFG_W:0]     rem_sh;
  logic               q_bit;
  cfg_t               rem_next;
  logic               inc;
  logic [CFG_W+1:0]   sub_t;
  logic [CFG_W:0]     add_t;
  cfg_t               wait_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Subtract the period from the elapsed time and saturate to 32 bits
  always_comb begin
    drift_full = {elapsed[TS_W], elapsed} - {2'b00, {(TS_W-CFG_W){1'b0}}, period};
    if (drift_full[TS_W+1:DRIFT_W-1] == '0 || drift_full[TS_W+1:DRIFT_W-1] == '1) begin
      drift_next = drift_full[DRIFT_W-1:0];
    end else if (drift_full[TS_W+1]) begin
      drift_next = {1'b1, {(DRIFT_W-1){1'b0}}};
    end else begin
      drift_next = {1'b0, {(DRIFT_W-1){1'b1}}};
    end
  end

  // Add this drift to the running sum, saturating at the 56-bit limits
  always_comb begin
    sum_full = {total[TOTAL_W-1], total}
             + {{(TOTAL_W-DRIFT_W+1){drift[DRIFT_W-1]}}, drift};
    if (sum_full[TOTAL_W] == sum_full[TOTAL_W-1]) begin
      total_next = sum_full[TOTAL_W-1:0];
    end else if (sum_full[TOTAL_W]) begin
      total_next = {1'b1, {(TOTAL_W-1){1'b0}}};
    end else begin
      total_next = {1'b0, {(TOTAL_W-1){1'b1}}};
    end
  end

  // One restoring division step: shift in a dividend bit, try to subtract
  always_comb begin
    rem_sh = {rem, dvd[TOTAL_W-1]};
    q_bit  = (rem_sh >= {1'b0, divisor});
    if (q_bit) begin
      rem_next = rem_sh[CFG_W-1:0] - divisor;
    end else begin
      rem_next = rem_sh[CFG_W-1:0];
    end
  end

  // Form the wait from the period and the rounded-up mean drift, clamped
  always_comb begin
    inc   = !neg && (rem != '0);
    sub_t = {2'b00, period} - {2'b00, dvd[CFG_W-1:0]} - {{(CFG_W+1){1'b0}}, inc};
    add_t = {1'b0, period} + {1'b0, dvd[CFG_W-1:0]};
    if (first) begin
      wait_next = period;
    end else if (!neg) begin
      if (dvd[TOTAL_W-1:CFG_W] != '0 || sub_t[CFG_W+1]) begin
        wait_next = '0;
      end else begin
        wait_next = sub_t[CFG_W-1:0];
      end
    end else begin
      if (dvd[TOTAL_W-1:CFG_W] != '0 || add_t[CFG_W]) begin
        wait_next = CFG_MAX;
      end else begin
        wait_next = add_t[CFG_W-1:0];
      end
    end
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
      limit  <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PERIOD: period <= cfg_data;
        REG_LIMIT:  limit  <= cfg_data;
        default:    period <= period;
      endcase
    end
  end

  // Sequence one item through the steps and hold the timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      prev  <= '0;
      count <= '0;
      total <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_ELAP;
          end
        end
        S_ELAP: begin
          prev  <= ts;
          if (count != CFG_MAX) begin
            count <= count + 1'b1;
          end
          state <= S_DRIFT;
        end
        S_DRIFT: begin
          state <= first ? S_FIN : S_ACCUM;
        end
        S_ACCUM: begin
          total <= total_next;
          state <= S_LOAD;
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (bit_cnt == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers of the item in flight
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          ts <= timestamp_us;
        end
      end
      S_ELAP: begin
        elapsed <= {1'b0, ts} - {1'b0, prev};
        first   <= (count == '0);
        last    <= (count != CFG_MAX) && ((count + 1'b1) == limit);
        divisor <= count;
      end
      S_DRIFT: begin
        drift <= drift_next;
      end
      S_LOAD: begin
        neg     <= total[TOTAL_W-1];
        dvd     <= total[TOTAL_W-1] ? (~total + 1'b1) : total;
        rem     <= '0;
        bit_cnt <= DIV_LAST;
      end
      S_DIV: begin
        dvd     <= {dvd[TOTAL_W-2:0], q_bit};
        rem     <= rem_next;
        bit_cnt <= bit_cnt - 1'b1;
      end
      default: begin
        bit_cnt <= bit_cnt;
      end
    endcase
  end

  // Output register: load on the last step, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      drift_us    <= drift;
      wait_us     <= wait_next;
      last_firing <= last;
    end
  end

  // The divider counts down one bit per cycle until it finishes
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && bit_cnt != '0) |=> (state == S_DIV && bit_cnt == $past(bit_cnt) - 1'b1))
    else $error("divider bit counter out of step");

  // The partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < divisor))
    else $error("divider remainder not below divisor");

  // The firing count never goes back
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (count >= $past(count)))
    else $error("firing count decreased");

  // A new result appears only from the last step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result raised outside the last step");

endmodule
